// ===== hdl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Holds the operation and status codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package ole_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WIDTH_DEF = 32;

    // Fixed widths of the item fields at the ports.
    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int FOUND_W   = 6;
    localparam int CNT_OUT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 3'd0,
        OP_APPEND  = 3'd1,
        OP_INSERT  = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_DELETE  = 3'd4,
        OP_REVERSE = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_INDEX = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_INC,
        PTR_DEC,
        PTR_ZERO,
        PTR_POS,
        PTR_CNT_M1,
        PTR_HI,
        PTR_LO_P1
    } t_ptr_op;

    typedef enum logic [2:0] {
        WA_POS,
        WA_CNT,
        WA_PTR_P1,
        WA_PTR_M1,
        WA_LO,
        WA_HI
    } t_waddr_sel;

    typedef enum logic [1:0] {
        WD_VAL,
        WD_RDATA,
        WD_HOLD
    } t_wdata_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic       load;
        t_ptr_op    ptr_op;
        logic       lohi_init;
        logic       lohi_step;
        logic       we;
        t_waddr_sel waddr_sel;
        t_wdata_sel wdata_sel;
        t_cnt_op    cnt_op;
        logic       set_status;
        t_status    status;
        logic       cap_found;
        logic       cap_removed;
        logic       cap_hold;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic pos_lt_cnt;
        logic pos_le_cnt;
        logic cnt_full;
        logic cnt_zero;
        logic cnt_gt1;
        logic ptr_gt_pos;
        logic ptr1_lt_cnt;
        logic lo2_lt_hi;
        logic match;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/ole_ctrl.sv =====
// Sequencer of the ordered list engine: one state machine that steps each
// operation through the datapath. Depends on ole_pkg for the command and status structs.
`default_nettype none

module ole_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire ole_pkg::t_dp_stat i_stat,
    output ole_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_CAP,
        S_DEL_SHIFT,
        S_SRCH,
        S_REV_A,
        S_REV_B,
        S_REV_C,
        S_FIN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    ole_pkg::t_dp_cmd cmd;
    logic             in_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FIN;
                case (i_stat.op)
                    ole_pkg::OP_WRITE: begin
                        if (i_stat.pos_lt_cnt) begin
                            cmd.we        = 1'b1;
                            cmd.waddr_sel = ole_pkg::WA_POS;
                            cmd.wdata_sel = ole_pkg::WD_VAL;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::STS_BAD_INDEX;
                        end
                    end
                    ole_pkg::OP_APPEND: begin
                        if (i_stat.cnt_full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::STS_FULL;
                        end else begin
                            cmd.we        = 1'b1;
                            cmd.waddr_sel = ole_pkg::WA_CNT;
                            cmd.wdata_sel = ole_pkg::WD_VAL;
                            cmd.cnt_op    = ole_pkg::CNT_INC;
                        end
                    end
                    ole_pkg::OP_INSERT: begin
                        if (!i_stat.pos_le_cnt) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::STS_BAD_INDEX;
                        end else if (i_stat.cnt_full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::STS_FULL;
                        end else if (!i_stat.pos_lt_cnt) begin
                            // Insert at the end needs no shifting.
                            cmd.we        = 1'b1;
                            cmd.waddr_sel = ole_pkg::WA_POS;
                            cmd.wdata_sel = ole_pkg::WD_VAL;
                            cmd.cnt_op    = ole_pkg::CNT_INC;
                        end else begin
                            cmd.ptr_op = ole_pkg::PTR_CNT_M1;
                            n_state    = S_INS_SHIFT;
                        end
                    end
                    ole_pkg::OP_SEARCH: begin
                        if (i_stat.cnt_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::STS_NOT_FOUND;
                        end else begin
                            cmd.ptr_op = ole_pkg::PTR_ZERO;
                            n_state    = S_SRCH;
                        end
                    end
                    ole_pkg::OP_DELETE: begin
                        if (i_stat.pos_lt_cnt) begin
                            cmd.ptr_op = ole_pkg::PTR_POS;
                            n_state    = S_DEL_CAP;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::STS_BAD_INDEX;
                        end
                    end
                    ole_pkg::OP_REVERSE: begin
                        if (i_stat.cnt_gt1) begin
                            cmd.ptr_op    = ole_pkg::PTR_ZERO;
                            cmd.lohi_init = 1'b1;
                            n_state       = S_REV_A;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                // The entry read last cycle moves up by one place.
                cmd.we        = 1'b1;
                cmd.waddr_sel = ole_pkg::WA_PTR_P1;
                cmd.wdata_sel = ole_pkg::WD_RDATA;
                if (i_stat.ptr_gt_pos) begin
                    cmd.ptr_op = ole_pkg::PTR_DEC;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = ole_pkg::WA_POS;
                cmd.wdata_sel = ole_pkg::WD_VAL;
                cmd.cnt_op    = ole_pkg::CNT_INC;
                n_state       = S_FIN;
            end
            S_DEL_CAP: begin
                cmd.cap_removed = 1'b1;
                if (i_stat.ptr1_lt_cnt) begin
                    cmd.ptr_op = ole_pkg::PTR_INC;
                    n_state    = S_DEL_SHIFT;
                end else begin
                    cmd.cnt_op = ole_pkg::CNT_DEC;
                    n_state    = S_FIN;
                end
            end
            S_DEL_SHIFT: begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = ole_pkg::WA_PTR_M1;
                cmd.wdata_sel = ole_pkg::WD_RDATA;
                if (i_stat.ptr1_lt_cnt) begin
                    cmd.ptr_op = ole_pkg::PTR_INC;
                end else begin
                    cmd.cnt_op = ole_pkg::CNT_DEC;
                    n_state    = S_FIN;
                end
            end
            S_SRCH: begin
                if (i_stat.match) begin
                    cmd.cap_found = 1'b1;
                    n_state       = S_FIN;
                end else if (i_stat.ptr1_lt_cnt) begin
                    cmd.ptr_op = ole_pkg::PTR_INC;
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ole_pkg::STS_NOT_FOUND;
                    n_state        = S_FIN;
                end
            end
            S_REV_A: begin
                // Low entry is in the read register; keep it and fetch the high one.
                cmd.cap_hold = 1'b1;
                cmd.ptr_op   = ole_pkg::PTR_HI;
                n_state      = S_REV_B;
            end
            S_REV_B: begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = ole_pkg::WA_LO;
                cmd.wdata_sel = ole_pkg::WD_RDATA;
                n_state       = S_REV_C;
            end
            S_REV_C: begin
                cmd.we        = 1'b1;
                cmd.waddr_sel = ole_pkg::WA_HI;
                cmd.wdata_sel = ole_pkg::WD_HOLD;
                cmd.lohi_step = 1'b1;
                cmd.ptr_op    = ole_pkg::PTR_LO_P1;
                n_state       = i_stat.lo2_lt_hi ? S_REV_A : S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("result register loaded but no valid result shown");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_DISPATCH))
        else $error("accepted item was not dispatched");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && i_out_stall) |=> (r_state == S_FIN))
        else $error("finished item overwrote a result still waiting");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !cmd.we && (cmd.cnt_op == ole_pkg::CNT_HOLD))
        else $error("list changed while idle");

endmodule

`default_nettype wire

// ===== hdl/ole_dpath.sv =====
// Datapath of the ordered list engine: entry memory, count, walk pointers,
// and the result registers. Depends on ole_pkg; driven by ole_ctrl commands.
`default_nettype none

module ole_dpath #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF,
    parameter int WIDTH = ole_pkg::WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ole_pkg::t_dp_cmd               i_cmd,
    output ole_pkg::t_dp_stat                   o_stat,
    input  wire logic [ole_pkg::OP_W-1:0]       i_operation,
    input  wire logic [ole_pkg::POS_W-1:0]      i_position,
    input  wire logic signed [ole_pkg::VAL_W-1:0] i_value,
    output logic [ole_pkg::STATUS_W-1:0]        o_status,
    output logic [ole_pkg::FOUND_W-1:0]         o_found_position,
    output logic [ole_pkg::VAL_W-1:0]           o_removed_value,
    output logic [ole_pkg::CNT_OUT_W-1:0]       o_entry_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int AW1  = AW + 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (ole_pkg::POS_W > CW) ? ole_pkg::POS_W : CW;

    logic [WIDTH-1:0]                r_mem [DEPTH];
    logic [WIDTH-1:0]                r_rdata;
    logic [WIDTH-1:0]                r_hold;
    logic [WIDTH-1:0]                r_val;
    logic [WIDTH-1:0]                r_removed;
    ole_pkg::t_op                    r_op;
    logic [ole_pkg::POS_W-1:0]       r_pos;
    logic [CW-1:0]                   r_count;
    logic [AW-1:0]                   r_ptr;
    logic [AW-1:0]                   n_ptr;
    logic [AW-1:0]                   r_lo;
    logic [AW-1:0]                   r_hi;
    ole_pkg::t_status                r_status;
    logic [ole_pkg::FOUND_W-1:0]     r_found;

    ole_pkg::t_status                r_o_status;
    logic [ole_pkg::FOUND_W-1:0]     r_o_found;
    logic [ole_pkg::VAL_W-1:0]       r_o_removed;
    logic [ole_pkg::CNT_OUT_W-1:0]   r_o_count;

    logic [AW-1:0]                   mem_waddr;
    logic [WIDTH-1:0]                mem_wdata;

    always_comb begin
        o_stat.op          = r_op;
        o_stat.pos_lt_cnt  = CMPW'(r_pos) < CMPW'(r_count);
        o_stat.pos_le_cnt  = CMPW'(r_pos) <= CMPW'(r_count);
        o_stat.cnt_full    = (r_count == CW'(DEPTH));
        o_stat.cnt_zero    = (r_count == '0);
        o_stat.cnt_gt1     = (r_count > CW'(1));
        o_stat.ptr_gt_pos  = CMPW'(r_ptr) > CMPW'(r_pos);
        o_stat.ptr1_lt_cnt = (CW'(r_ptr) + CW'(1)) < r_count;
        o_stat.lo2_lt_hi   = (AW1'(r_lo) + AW1'(2)) < AW1'(r_hi);
        o_stat.match       = (r_rdata == r_val);
    end

    // The memory is read at the pointer's next value, so the read register
    // always holds the entry at the current pointer.
    always_comb begin
        case (i_cmd.ptr_op)
            ole_pkg::PTR_HOLD:   n_ptr = r_ptr;
            ole_pkg::PTR_INC:    n_ptr = r_ptr + AW'(1);
            ole_pkg::PTR_DEC:    n_ptr = r_ptr - AW'(1);
            ole_pkg::PTR_ZERO:   n_ptr = '0;
            ole_pkg::PTR_POS:    n_ptr = AW'(r_pos);
            ole_pkg::PTR_CNT_M1: n_ptr = AW'(r_count - CW'(1));
            ole_pkg::PTR_HI:     n_ptr = r_hi;
            ole_pkg::PTR_LO_P1:  n_ptr = r_lo + AW'(1);
            default:             n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.waddr_sel)
            ole_pkg::WA_POS:    mem_waddr = AW'(r_pos);
            ole_pkg::WA_CNT:    mem_waddr = AW'(r_count);
            ole_pkg::WA_PTR_P1: mem_waddr = r_ptr + AW'(1);
            ole_pkg::WA_PTR_M1: mem_waddr = r_ptr - AW'(1);
            ole_pkg::WA_LO:     mem_waddr = r_lo;
            ole_pkg::WA_HI:     mem_waddr = r_hi;
            default:            mem_waddr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.wdata_sel)
            ole_pkg::WD_VAL:   mem_wdata = r_val;
            ole_pkg::WD_RDATA: mem_wdata = r_rdata;
            ole_pkg::WD_HOLD:  mem_wdata = r_hold;
            default:           mem_wdata = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.cnt_op)
                ole_pkg::CNT_INC: r_count <= r_count + CW'(1);
                ole_pkg::CNT_DEC: r_count <= r_count - CW'(1);
                default:          r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_op      <= ole_pkg::t_op'(i_operation);
            r_pos     <= i_position;
            r_val     <= WIDTH'($unsigned(i_value));
            r_status  <= ole_pkg::STS_OK;
            r_found   <= '0;
            r_removed <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.cap_found) begin
            r_found <= ole_pkg::FOUND_W'(r_ptr);
        end
        if (i_cmd.cap_removed) begin
            r_removed <= r_rdata;
        end
        if (i_cmd.cap_hold) begin
            r_hold <= r_rdata;
        end
        if (i_cmd.lohi_init) begin
            r_lo <= '0;
            r_hi <= AW'(r_count - CW'(1));
        end else if (i_cmd.lohi_step) begin
            r_lo <= r_lo + AW'(1);
            r_hi <= r_hi - AW'(1);
        end
        if (i_cmd.out_load) begin
            r_o_status  <= r_status;
            r_o_found   <= r_found;
            r_o_removed <= ole_pkg::VAL_W'(r_removed);
            r_o_count   <= ole_pkg::CNT_OUT_W'(r_count);
        end
    end

    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_removed_value  = r_o_removed;
    assign o_entry_count    = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == ole_pkg::CNT_INC) |-> (r_count < CW'(DEPTH)))
        else $error("entry added to a full list");

    a_dec_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cnt_op == ole_pkg::CNT_DEC) |-> (r_count != '0))
        else $error("entry removed from an empty list");

endmodule

`default_nettype wire

// ===== hdl/ordered_list_engine.sv =====
// Top level of the ordered list engine: a fixed-capacity list of values.
// Instantiates ole_ctrl and ole_dpath; uses ole_pkg.
//
//   Channel  Direction  Handshake               Fields
//   input    in         i_in_valid / o_in_stall i_operation, i_position, i_value
//   output   out        o_out_valid / i_out_stall
//                                               o_status, o_found_position,
//                                               o_removed_value, o_entry_count
//
// One item is worked at a time: a new item is taken only once the last result
// is loaded into the output register. Write, append, an unused code, insert at the end,
// reverse of under two entries and any rejected item need no walk; insert and delete
// shift the entries above the position, search walks up from index 0 to the first match,
// and reverse swaps pairs from both ends inward. A waiting result holds in the output register
// while the next item is worked, and that item's result waits until the first one leaves. Reset empties the list.
`default_nettype none

module ordered_list_engine #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF,
    parameter int WIDTH = ole_pkg::WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [ole_pkg::OP_W-1:0]         i_operation,
    input  wire logic [ole_pkg::POS_W-1:0]        i_position,
    input  wire logic signed [ole_pkg::VAL_W-1:0] i_value,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [ole_pkg::STATUS_W-1:0]          o_status,
    output logic [ole_pkg::FOUND_W-1:0]           o_found_position,
    output logic signed [ole_pkg::VAL_W-1:0]      o_removed_value,
    output logic [ole_pkg::CNT_OUT_W-1:0]         o_entry_count
);

    ole_pkg::t_dp_cmd            cmd;
    ole_pkg::t_dp_stat           stat;
    logic [ole_pkg::VAL_W-1:0]   removed_value;

    ole_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ole_dpath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_removed_value  (removed_value),
        .o_entry_count    (o_entry_count)
    );

    assign o_removed_value = $signed(removed_value);

endmodule

`default_nettype wire

// ===== tb/ordered_list_engine_tb.sv =====
// Self-checking testbench for ordered_list_engine, the fixed-capacity list block.
// Depends on ole_pkg for the operation and status codes. A local list mirror
// predicts every result. Both sides of the handshake idle and stall at random outside the calm run.
`timescale 1ns / 1ps

module ordered_list_engine_tb;

    localparam int LIST_DEPTH = ole_pkg::DEPTH_DEF;

    // Codes 6 and 7 have no operation behind them.
    localparam logic [ole_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [ole_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        ole_pkg::t_status                     status;
        logic [ole_pkg::FOUND_W-1:0]          found;
        logic signed [ole_pkg::VAL_W-1:0]     removed;
        logic [ole_pkg::CNT_OUT_W-1:0]        count;
    } t_list_result;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_in_valid = 1'b0;
    logic                                   o_in_stall;
    logic [ole_pkg::OP_W-1:0]               i_operation = '0;
    logic [ole_pkg::POS_W-1:0]              i_position = '0;
    logic signed [ole_pkg::VAL_W-1:0]       i_value = '0;
    logic                                   o_out_valid;
    logic                                   i_out_stall = 1'b0;
    logic [ole_pkg::STATUS_W-1:0]           o_status;
    logic [ole_pkg::FOUND_W-1:0]            o_found_position;
    logic signed [ole_pkg::VAL_W-1:0]       o_removed_value;
    logic [ole_pkg::CNT_OUT_W-1:0]          o_entry_count;

    // Mirror of the list contents and length, updated as each transfer is accepted.
    logic [ole_pkg::VAL_W-1:0]  list_mirror [LIST_DEPTH];
    int                         list_len = 0;
    t_list_result               expected_results [$];
    int                         n_fail = 0;
    bit                         calm_run = 1'b0;

    ordered_list_engine i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_removed_value  (o_removed_value),
        .o_entry_count    (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_list_result apply_list_op(
        input logic [ole_pkg::OP_W-1:0]  op,
        input logic [ole_pkg::POS_W-1:0] pos,
        input logic [ole_pkg::VAL_W-1:0] val);
        t_list_result r;
        int i;
        int lo;
        int hi;
        logic [ole_pkg::VAL_W-1:0] tmp;
        r = '0;
        r.status = ole_pkg::STS_OK;
        case (op)
            ole_pkg::OP_WRITE: begin
                if (pos >= list_len) r.status = ole_pkg::STS_BAD_INDEX;
                else list_mirror[pos] = val;
            end
            ole_pkg::OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = ole_pkg::STS_FULL;
                end else begin
                    list_mirror[list_len] = val;
                    list_len++;
                end
            end
            ole_pkg::OP_INSERT: begin
                // The index check wins over the full check.
                if (pos > list_len) begin
                    r.status = ole_pkg::STS_BAD_INDEX;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = ole_pkg::STS_FULL;
                end else begin
                    for (i = list_len; i > pos; i--) list_mirror[i] = list_mirror[i - 1];
                    list_mirror[pos] = val;
                    list_len++;
                end
            end
            ole_pkg::OP_SEARCH: begin
                r.status = ole_pkg::STS_NOT_FOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_mirror[i] == val) begin
                        r.status = ole_pkg::STS_OK;
                        r.found = 6'(i);
                        break;
                    end
                end
            end
            ole_pkg::OP_DELETE: begin
                if (pos >= list_len) begin
                    r.status = ole_pkg::STS_BAD_INDEX;
                end else begin
                    r.removed = list_mirror[pos];
                    for (i = pos; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i + 1];
                    list_len--;
                end
            end
            ole_pkg::OP_REVERSE: begin
                lo = 0;
                hi = list_len - 1;
                while (lo < hi) begin
                    tmp = list_mirror[lo];
                    list_mirror[lo] = list_mirror[hi];
                    list_mirror[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            default: ;
        endcase
        r.count = 7'(list_len);
        return r;
    endfunction

    function automatic logic [ole_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            // A small pool of values gives duplicates, so searches must find the first.
            2, 3: return 32'($urandom_range(6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ole_pkg::VAL_W-1:0] pick_key();
        if (list_len > 0 && $urandom_range(99) < 65)
            return list_mirror[$urandom_range(list_len - 1)];
        return pick_value();
    endfunction

    function automatic logic [ole_pkg::POS_W-1:0] pick_position();
        int w;
        w = $urandom_range(99);
        if (w < 80) return 7'($urandom_range(list_len));
        if (w < 95) return 7'($urandom_range(LIST_DEPTH));
        return 7'($urandom_range(127));
    endfunction

    // Drives one item and waits for its transfer. Valid stays high on return,
    // so back-to-back items need no extra assignment in the same step.
    task automatic send_op(input logic [ole_pkg::OP_W-1:0] op,
                           input logic [ole_pkg::POS_W-1:0] pos,
                           input logic [ole_pkg::VAL_W-1:0] val);
        if (!calm_run) begin
            while ($urandom_range(99) < 21) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_results.push_back(apply_list_op(op, pos, val));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        send_op(ole_pkg::OP_SEARCH, 7'd0, 32'd0);
        send_op(ole_pkg::OP_DELETE, 7'd0, 32'd0);
        send_op(ole_pkg::OP_WRITE, 7'd0, 32'h1234_5678);
        send_op(ole_pkg::OP_REVERSE, 7'd0, 32'd0);
        send_op(ole_pkg::OP_INSERT, 7'd1, 32'd9);
        send_op(ole_pkg::OP_INSERT, 7'd0, 32'h8000_0000);
        send_op(ole_pkg::OP_REVERSE, 7'd0, 32'd0);
    endtask

    task automatic test_small_list();
        send_op(ole_pkg::OP_APPEND, 7'd127, 32'h7FFF_FFFF);
        send_op(ole_pkg::OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_op(ole_pkg::OP_APPEND, 7'd64, 32'd0);
        send_op(ole_pkg::OP_WRITE, 7'd1, 32'h5555_5555);
        send_op(ole_pkg::OP_WRITE, 7'd4, 32'hAAAA_AAAA);
        send_op(ole_pkg::OP_WRITE, 7'd127, 32'd1);
        send_op(ole_pkg::OP_INSERT, 7'd4, 32'd0);
        send_op(ole_pkg::OP_SEARCH, 7'd0, 32'h8000_0000);
        send_op(ole_pkg::OP_SEARCH, 7'd0, 32'd0);
        send_op(ole_pkg::OP_SEARCH, 7'd0, 32'h0BAD_F00D);
        send_op(ole_pkg::OP_REVERSE, 7'd0, 32'd0);
        send_op(ole_pkg::OP_DELETE, 7'd4, 32'd0);
        send_op(ole_pkg::OP_DELETE, 7'd0, 32'd0);
        send_op(ole_pkg::OP_DELETE, 7'd3, 32'd0);
        send_op(OP_UNUSED_6, 7'd127, 32'hFFFF_FFFF);
        send_op(OP_UNUSED_7, 7'd0, 32'h8000_0000);
        send_op(ole_pkg::OP_REVERSE, 7'd0, 32'd0);
    endtask

    task automatic test_full_list();
        while (list_len < LIST_DEPTH)
            send_op(ole_pkg::OP_APPEND, 7'($urandom_range(127)), pick_value());
        send_op(ole_pkg::OP_APPEND, 7'd0, 32'd5);
        send_op(ole_pkg::OP_INSERT, 7'd64, 32'd5);
        send_op(ole_pkg::OP_INSERT, 7'd65, 32'd5);
        send_op(ole_pkg::OP_INSERT, 7'd0, 32'd5);
        send_op(ole_pkg::OP_WRITE, 7'd63, $urandom);
        send_op(ole_pkg::OP_WRITE, 7'd64, $urandom);
        send_op(ole_pkg::OP_SEARCH, 7'd0, list_mirror[63]);
        send_op(ole_pkg::OP_REVERSE, 7'd0, 32'd0);
        send_op(ole_pkg::OP_DELETE, 7'd64, 32'd0);
        send_op(ole_pkg::OP_DELETE, 7'd63, 32'd0);
        send_op(ole_pkg::OP_INSERT, 7'd31, $urandom);
        send_op(ole_pkg::OP_DELETE, 7'd0, 32'd0);
        while (list_len > 0)
            send_op(ole_pkg::OP_DELETE, 7'($urandom_range(list_len - 1)), 32'd0);
        send_op(ole_pkg::OP_SEARCH, 7'd0, 32'd0);
    endtask

    task automatic test_random_traffic();
        int n;
        int w;
        bit grow;
        logic [ole_pkg::OP_W-1:0] op;
        for (n = 0; n < 1250; n++) begin
            // Alternate growing and shrinking phases so that both full and empty lists come up.
            grow = ((n / 120) % 2) == 0;
            if (n == 400) wait_for_results();
            calm_run = (n >= 600 && n < 800);
            w = $urandom_range(99);
            if (w < 1)
                op = $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
            else if (w < (grow ? 26 : 6))
                op = ole_pkg::OP_APPEND;
            else if (w < (grow ? 51 : 16))
                op = ole_pkg::OP_INSERT;
            else if (w < (grow ? 66 : 31))
                op = ole_pkg::OP_WRITE;
            else if (w < (grow ? 86 : 51))
                op = ole_pkg::OP_SEARCH;
            else if (w < (grow ? 96 : 91))
                op = ole_pkg::OP_DELETE;
            else
                op = ole_pkg::OP_REVERSE;
            send_op(op, pick_position(),
                    (op == ole_pkg::OP_SEARCH) ? pick_key() : pick_value());
        end
        calm_run = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || calm_run) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < 21);
    end

    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                $error("result with no item waiting: status %0d count %0d",
                       o_status, o_entry_count);
                n_fail++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    n_fail++;
                end
                if (o_found_position !== exp_r.found) begin
                    $error("found_position: expected %0d, got %0d",
                           exp_r.found, o_found_position);
                    n_fail++;
                end
                if (o_removed_value !== exp_r.removed) begin
                    $error("removed_value: expected %0d, got %0d",
                           exp_r.removed, o_removed_value);
                    n_fail++;
                end
                if (o_entry_count !== exp_r.count) begin
                    $error("entry_count: expected %0d, got %0d", exp_r.count, o_entry_count);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_small_list();
        test_full_list();
        test_random_traffic();
        wait_for_results();
        // Leave room for any result that should not be there.
        repeat (120) @(posedge i_clk);
        if (n_fail == 0)
            $display("** ordered_list_engine: PASSED **");
        else
            $display("** ordered_list_engine: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** ordered_list_engine: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ole_pkg.sv
hdl/ole_ctrl.sv
hdl/ole_dpath.sv
hdl/ordered_list_engine.sv
tb/ordered_list_engine_tb.sv
